@@ rtl/fasta_two_bit_packer_unit_defines.svh @@
// Assertion macros used by the checker file of the FASTA two-bit packer.
`ifndef FASTA_TWO_BIT_PACKER_UNIT_DEFINES_SVH
`define FASTA_TWO_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FTBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftbp assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FTBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftbp assertion failed");

`endif

@@ rtl/ftbp_pkg.sv @@
// Shared types and constants of the FASTA two-bit packer.
package ftbp_pkg;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam int BASE_FLAG_BIT = 6;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		OP_HDR   = 2'd0,
		OP_BASE  = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	// One classified request handed from the front end to the packer.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [1:0] code;
		logic       eoi;
	} cmd_t;

endpackage

@@ rtl/ftbp_in_if.sv @@
// Input stream channel: one FASTA byte per request.
interface ftbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ rtl/ftbp_out_if.sv @@
// Output stream channel: one header byte or packed base byte per request.
interface ftbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_header;
	logic [2:0] base_count;
	logic       last;

	modport source (output valid, output out_byte, output is_header, output base_count,
		output last, input ready);
	modport sink (input valid, input out_byte, input is_header, input base_count,
		input last, output ready);
endinterface

@@ rtl/ftbp_front.sv @@
// Front end: accepts stream bytes, tracks header mode and classifies each byte.
module ftbp_front (
	input  logic          clk,
	input  logic          arst_n,
	ftbp_in_if.sink       in_ch,
	input  logic          q_full,
	output logic          push,
	output ftbp_pkg::cmd_t push_cmd
);
	import ftbp_pkg::*;

	logic in_header_q;
	logic accept;
	logic keep;

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		keep = 1'b1;
		push_cmd.data = in_ch.in_byte;
		push_cmd.code = in_ch.in_byte[2:1];
		push_cmd.eoi = in_ch.end_of_input;
		if (in_header_q) begin
			push_cmd.op = OP_HDR;
		end else if (in_ch.in_byte[BASE_FLAG_BIT]) begin
			push_cmd.op = OP_BASE;
		end else begin
			// A skipped body byte only matters when it closes the stream.
			push_cmd.op = OP_FLUSH;
			keep = in_ch.end_of_input;
		end
	end

	assign push = accept && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b1;
		end else if (accept) begin
			if (in_ch.end_of_input) begin
				in_header_q <= 1'b1;
			end else if (in_header_q && in_ch.in_byte == NEWLINE_CHAR) begin
				in_header_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/ftbp_queue.sv @@
// Small FIFO of classified requests between the front end and the packer.
module ftbp_queue #(
	parameter int DEPTH = ftbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ftbp_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output ftbp_pkg::cmd_t head,
	output logic           empty
);
	import ftbp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

@@ rtl/ftbp_back.sv @@
// Back end: collects base codes, packs four per byte and drives the output register.
module ftbp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ftbp_pkg::cmd_t head,
	input  logic           q_empty,
	output logic           pop,
	ftbp_out_if.source     out_ch
);
	import ftbp_pkg::*;

	logic [5:0] codes_q;
	logic [1:0] count_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       hdr_q;
	logic [2:0] cnt_q;
	logic       last_q;

	logic       emit;
	logic [7:0] res_byte;
	logic       res_hdr;
	logic [2:0] res_cnt;
	logic       res_last;
	logic [5:0] codes_d;
	logic [1:0] count_d;
	logic [5:0] codes_w;

	// Left-aligns n pending codes and pads the rest of the byte with zero codes.
	function automatic logic [7:0] pad_codes(input logic [5:0] codes, input logic [1:0] n);
		logic [7:0] r;
		case (n)
			2'd1:    r = {codes[1:0], 6'b0};
			2'd2:    r = {codes[3:0], 4'b0};
			2'd3:    r = {codes[5:0], 2'b0};
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	assign pop = !q_empty && (!valid_q || out_ch.ready);
	assign codes_w = {codes_q[3:0], head.code};

	always_comb begin
		emit = 1'b0;
		res_byte = head.data;
		res_hdr = 1'b0;
		res_cnt = 3'd0;
		res_last = head.eoi;
		codes_d = codes_q;
		count_d = count_q;
		unique case (head.op)
			OP_HDR: begin
				emit = 1'b1;
				res_hdr = 1'b1;
			end
			OP_BASE: begin
				if (count_q == 2'd3) begin
					emit = 1'b1;
					res_byte = {codes_q, head.code};
					res_cnt = 3'd4;
					codes_d = '0;
					count_d = '0;
				end else begin
					codes_d = codes_w;
					count_d = count_q + 1'b1;
					emit = head.eoi;
					res_byte = pad_codes(codes_w, count_q + 1'b1);
					res_cnt = {1'b0, count_q + 1'b1};
				end
			end
			OP_FLUSH: begin
				emit = 1'b1;
				res_byte = pad_codes(codes_q, count_q);
				res_cnt = {1'b0, count_q};
				res_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (head.eoi) begin
			codes_d = '0;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				codes_q <= codes_d;
				count_q <= count_d;
			end
			if (pop && emit) begin
				valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			byte_q <= res_byte;
			hdr_q <= res_hdr;
			cnt_q <= res_cnt;
			last_q <= res_last;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.out_byte = byte_q;
	assign out_ch.is_header = hdr_q;
	assign out_ch.base_count = cnt_q;
	assign out_ch.last = last_q;
endmodule

@@ rtl/fasta_two_bit_packer_unit.sv @@
// FASTA two-bit packer: takes one stream byte per cycle and delivers header bytes and
// packed base bytes via the request queue and output register. Rate is one byte per
// cycle when unstalled, set by the single push and pop per cycle of that queue and by
// that register, which frees itself in the same cycle its result is taken; bytes that
// produce no result are still taken at that rate. Header bytes pass through until the
// first newline; afterward bases pack four to a byte, first base in bits 7:6, and the
// final byte of a stream flushes any partial group padded with zero codes.
module fasta_two_bit_packer_unit #(
	parameter int QUEUE_DEPTH = ftbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ftbp_in_if.sink     in_ch,
	ftbp_out_if.source  out_ch
);
	import ftbp_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t head;
	logic q_empty;

	ftbp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	ftbp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty)
	);

	ftbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_empty(q_empty),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule

@@ rtl/ftbp_checker.sv @@
// Port-level checker of the FASTA two-bit packer and its bind to the top level.
`include "fasta_two_bit_packer_unit_defines.svh"

module ftbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_header,
	input logic [2:0] base_count,
	input logic       last
);
	// A stalled result keeps its request.
	`FTBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last))
	// Passed-through header bytes carry no bases.
	`FTBP_ASSERT_NOW(a_hdr_no_bases, out_valid && is_header, base_count == 3'd0)
	// A packed byte never claims more than four bases.
	`FTBP_ASSERT_NOW(a_cnt_range, out_valid && base_count[2], base_count[1:0] == 2'd0)
	// A body result without bases only closes a stream, and holds zero.
	`FTBP_ASSERT_NOW(a_empty_final, out_valid && !is_header && base_count == 3'd0, last && out_byte == 8'h00)
endmodule

bind fasta_two_bit_packer_unit ftbp_checker u_ftbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.is_header (out_ch.is_header),
	.base_count(out_ch.base_count),
	.last      (out_ch.last)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench of the FASTA two-bit packer: directed and random streams checked against a predictor.
module tb;
	import ftbp_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic [2:0] base_count;
		logic       last;
	} packer_result_t;

	logic clk;
	logic arst_n;

	ftbp_in_if in_ch ();
	ftbp_out_if out_ch ();

	fasta_two_bit_packer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Predicted packer state.
	bit         hdr_mode;
	logic [5:0] held_codes;
	logic [1:0] held_count;

	packer_result_t results_due[$];
	int error_count;
	int send_idle_pct;
	int stall_pct;
	int bytes_sent;

	logic [7:0] base_letters[8] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		packer_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (results_due.size() == 0) begin
				error_count++;
				$error("result with nothing expected: out_byte %h", out_ch.out_byte);
			end else begin
				want = results_due.pop_front();
				if (out_ch.out_byte !== want.out_byte) begin
					error_count++;
					$error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
				end
				if (out_ch.is_header !== want.is_header) begin
					error_count++;
					$error("is_header: expected %b, got %b", want.is_header, out_ch.is_header);
				end
				if (out_ch.base_count !== want.base_count) begin
					error_count++;
					$error("base_count: expected %0d, got %0d", want.base_count,
						out_ch.base_count);
				end
				if (out_ch.last !== want.last) begin
					error_count++;
					$error("last: expected %b, got %b", want.last, out_ch.last);
				end
			end
		end
	end

	// Advances the predicted state by one byte; returns 1 when a result is due.
	function automatic bit fasta_pack_step(input logic [7:0] b, input logic eoi,
		output packer_result_t r);
		logic [5:0] codes;
		logic [2:0] count;
		r = '0;
		if (hdr_mode) begin
			r.out_byte = b;
			r.is_header = 1'b1;
			r.last = eoi;
			if (eoi) begin
				held_codes = '0;
				held_count = '0;
			end else if (b == NEWLINE_CHAR) begin
				hdr_mode = 1'b0;
			end
			return 1'b1;
		end
		codes = held_codes;
		count = {1'b0, held_count};
		if (b[BASE_FLAG_BIT]) begin
			if (count == 3'd3) begin
				r.out_byte = {codes, b[2:1]};
				r.base_count = 3'd4;
				r.last = eoi;
				held_codes = '0;
				held_count = '0;
				if (eoi)
					hdr_mode = 1'b1;
				return 1'b1;
			end
			codes = {codes[3:0], b[2:1]};
			count = count + 3'd1;
		end
		if (!eoi) begin
			held_codes = codes;
			held_count = count[1:0];
			return 1'b0;
		end
		// A flush left-aligns the partial group; with nothing held the result is empty.
		r.last = 1'b1;
		if (count != 3'd0) begin
			r.base_count = count;
			r.out_byte = {codes, 2'b00} << (2 * (3 - count));
		end
		hdr_mode = 1'b1;
		held_codes = '0;
		held_count = '0;
		return 1'b1;
	endfunction

	// Starts and ends at a falling edge; the prediction is made at the accepting edge.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		packer_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.end_of_input <= eoi;
		do @(posedge clk); while (!in_ch.ready);
		if (fasta_pack_step(b, eoi, r))
			results_due.push_back(r);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_header_passthrough();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// Hold off mid-header until the output side has caught up.
		wait_drain();
		send_byte(8'h3E, 1'b0);
		send_byte(NEWLINE_CHAR, 1'b0);
	endtask

	task automatic test_base_packing();
		send_byte(8'h61, 1'b0);
		send_byte(8'h43, 1'b0);
		send_byte(8'h47, 1'b0);
		send_byte(8'h54, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(NEWLINE_CHAR, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'h30, 1'b1);
	endtask

	task automatic test_stream_ends();
		send_byte(NEWLINE_CHAR, 1'b1);
		send_byte(NEWLINE_CHAR, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(NEWLINE_CHAR, 1'b0);
		send_byte(8'h43, 1'b1);
		send_byte(NEWLINE_CHAR, 1'b0);
		send_byte(8'h47, 1'b0);
		send_byte(8'h67, 1'b0);
		send_byte(8'h47, 1'b0);
		send_byte(8'h54, 1'b1);
	endtask

	task automatic test_random_streams(input int idle_pct, input int stall_rate, input int count);
		int stop_at;
		int kind;
		int hdr_len;
		int body_len;
		logic [7:0] b;
		send_idle_pct = idle_pct;
		stall_pct = stall_rate;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				wait_drain();
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				// Noise, or a header cut short by the end of the stream.
				hdr_len = $urandom_range(1, 8);
				for (int i = 0; i < hdr_len; i++) begin
					b = ($urandom_range(0, 3) == 0) ? NEWLINE_CHAR : 8'($urandom);
					if (kind == 1 && b == NEWLINE_CHAR)
						b = 8'h3E;
					send_byte(b, i == hdr_len - 1);
				end
			end else begin
				hdr_len = $urandom_range(0, 10);
				for (int i = 0; i < hdr_len; i++) begin
					b = 8'($urandom);
					if (b == NEWLINE_CHAR)
						b = 8'h3E;
					send_byte(b, 1'b0);
				end
				send_byte(NEWLINE_CHAR, 1'b0);
				body_len = $urandom_range(1, 30);
				for (int i = 0; i < body_len; i++) begin
					case ($urandom_range(0, 9))
						0, 1: b = 8'($urandom);
						2: b = 8'($urandom) | 8'h40;
						default: b = base_letters[$urandom_range(0, 7)];
					endcase
					send_byte(b, i == body_len - 1);
				end
			end
		end
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.end_of_input = 1'b0;
		out_ch.ready = 1'b0;
		hdr_mode = 1'b1;
		held_codes = '0;
		held_count = '0;
		error_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_header_passthrough();
		test_base_packing();
		test_stream_ends();
		wait_drain();
		test_random_streams(14, 51, 360);
		test_random_streams(51, 14, 360);
		test_random_streams(0, 0, 360);

		stall_pct = 0;
		repeat (20) @(posedge clk);
		if (error_count == 0 && results_due.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
